[src/tsm_pkg.sv]
// ----------------------------------------------------------------------------
// Traction speed model package
// Shared constants, state codes and the serial operation sequence.
// ----------------------------------------------------------------------------
package tsm_pkg;

  localparam int unsigned SPINUP_RESET = 256;
  localparam int unsigned DRAG_RESET = 16;
  localparam int unsigned ROLLING_RESET = 26;
  localparam int unsigned BRAKE_RESET = 64;
  localparam int unsigned DRIVE_RESET = 256;
  localparam int unsigned SMOKE_THR_RESET = 256;
  localparam int unsigned SMOKE_WORK_RESET = 256;
  localparam int unsigned SMOKE_ACC_RESET = 2560;

  localparam int LEVEL_MAX = 25600;
  localparam int CREEP_LIMIT = 128;

  // Width of the serial multiplier's multiplier (b) operand.
  localparam int MUL_W = 32;

  typedef enum logic [3:0] {
    REG_SPINUP    = 4'd0,
    REG_DRAG      = 4'd1,
    REG_ROLLING   = 4'd2,
    REG_BRAKE     = 4'd3,
    REG_DRIVE     = 4'd4,
    REG_SMOKE_THR = 4'd5,
    REG_SMOKE_WRK = 4'd6,
    REG_SMOKE_ACC = 4'd7
  } reg_idx_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_SQRT = 7'b0000100,
    ST_NEXT = 7'b0001000,
    ST_FIN  = 7'b0010000,
    ST_OUT  = 7'b0100000,
    ST_PREP = 7'b1000000
  } state_t;

  // Serial operations of one tick, in order.
  typedef enum logic [2:0] {
    OP_SQ    = 3'd0,
    OP_AIR   = 3'd1,
    OP_BRAKE = 3'd2,
    OP_ROOT  = 3'd3,
    OP_DRIVE = 3'd4,
    OP_STHR  = 3'd5,
    OP_SWRK  = 3'd6,
    OP_SACC  = 3'd7
  } op_t;

endpackage

[src/traction_speed_model_step.sv]
// ----------------------------------------------------------------------------
// Traction speed model step
// Engine rpm, drag, drive and smoke of one physics tick per transaction.
// ----------------------------------------------------------------------------
// An engine switch transaction (action 0) goes from input acceptance straight
// to ST_OUT. A physics tick passes through ST_PREP and the serial operations
// before the result is valid. One bit-serial shift-add multiplier works through
// seven products. Each product is loaded in ST_NEXT, shifted and added in ST_MUL
// and finished in ST_FIN. A restoring square root unit takes two radicand bits
// per cycle. With the engine off the three smoke products are skipped, and with
// the throttle at or below rpm the throttle smoke product is skipped. Each tick
// runs to completion before the next transaction is taken. The result register
// holds the state after the transaction until the output side takes it. Input
// is stalled while a result waits.
module traction_speed_model_step
  import tsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic               engine_request,
  input  logic               master_switch,
  input  logic [14:0]        throttle,
  input  logic [14:0]        brake,
  input  logic signed [1:0]  reverser,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] speed_out,
  output logic [14:0]        rpm_out,
  output logic [14:0]        smoke_out,
  output logic               engine_running,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [14:0] spinup_step, rolling_step;
  logic [15:0] drag_coeff, brake_coeff, drive_coeff;
  logic [15:0] smoke_throttle_coeff, smoke_work_coeff, smoke_accel_coeff;

  always_ff @(posedge clk) begin
    if (rst) begin
      spinup_step <= 15'(SPINUP_RESET);
      drag_coeff <= 16'(DRAG_RESET);
      rolling_step <= 15'(ROLLING_RESET);
      brake_coeff <= 16'(BRAKE_RESET);
      drive_coeff <= 16'(DRIVE_RESET);
      smoke_throttle_coeff <= 16'(SMOKE_THR_RESET);
      smoke_work_coeff <= 16'(SMOKE_WORK_RESET);
      smoke_accel_coeff <= 16'(SMOKE_ACC_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPINUP:    spinup_step <= cfg_data[14:0];
        REG_DRAG:      drag_coeff <= cfg_data;
        REG_ROLLING:   rolling_step <= cfg_data[14:0];
        REG_BRAKE:     brake_coeff <= cfg_data;
        REG_DRIVE:     drive_coeff <= cfg_data;
        REG_SMOKE_THR: smoke_throttle_coeff <= cfg_data;
        REG_SMOKE_WRK: smoke_work_coeff <= cfg_data;
        REG_SMOKE_ACC: smoke_accel_coeff <= cfg_data;
        default: ;
      endcase
    end
  end

  // Architectural state.
  logic              engine_flag;
  logic [14:0]       rpm_level;
  logic signed [15:0] speed_level, prior_speed;
  logic [14:0]       smoke_level;

  state_t state;
  op_t    op;

  // Latched tick inputs.
  logic              t_master;
  logic [14:0]       t_throttle, t_brake;
  logic signed [1:0] t_rev;

  // Working values.
  logic signed [16:0] spd;     // speed after drag, later after drive
  logic [15:0]        mag;     // |speed| before drag
  logic [31:0]        sq;      // speed squared
  logic [23:0]        res;     // accumulated resistance
  logic [11:0]        root;    // sqrt result
  logic [24:0]        smoke;   // accumulated smoke
  logic [15:0]        accel;   // speed increase

  // Bit-serial multiplier: multiplicand a, multiplier b shifted out LSB first.
  logic [47:0] m_a;
  logic [31:0] m_b;
  logic [47:0] m_acc;
  logic [4:0]  m_cnt;

  // Restoring square root, two bits per cycle.
  logic [23:0] r_v;
  logic [23:0] r_rem;
  logic [11:0] r_res;
  logic [3:0]  r_cnt;
  logic [25:0] r_trial;

  assign in_stall = (state != ST_IDLE) || out_valid;
  assign r_trial = {r_rem, r_v[23:22]} - {12'd0, r_res, 2'b01};

  // Next rpm is purely combinational on the latched inputs.
  logic signed [17:0] rpm_calc;
  always_comb begin
    rpm_calc = 18'($signed({3'd0, rpm_level}));
    if (engine_flag && t_master) begin
      if ({2'b0, rpm_level, 1'b0} + {3'd0, spinup_step} < {2'b0, t_throttle, 1'b0})
        rpm_calc = rpm_calc + 18'($signed({3'd0, spinup_step}));
      else if ({2'b0, rpm_level, 1'b0} > {2'b0, t_throttle, 1'b0} + {3'd0, spinup_step})
        rpm_calc = rpm_calc - 18'($signed({3'd0, spinup_step}));
    end else begin
      rpm_calc = rpm_calc - 18'($signed({3'd0, spinup_step}));
    end
  end

  // Operand selection for each serial product.
  logic [47:0] op_a;
  logic [31:0] op_b;
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (op)
      OP_SQ:    begin op_a = {32'd0, mag}; op_b = {16'd0, mag}; end
      OP_AIR:   begin op_a = {16'd0, sq}; op_b = {16'd0, drag_coeff}; end
      OP_BRAKE: begin op_a = {33'd0, t_brake}; op_b = {16'd0, brake_coeff}; end
      OP_DRIVE: begin op_a = {36'd0, root}; op_b = {16'd0, drive_coeff}; end
      OP_STHR:  begin
        op_a = {33'd0, t_throttle - rpm_level};
        op_b = {16'd0, smoke_throttle_coeff};
      end
      OP_SWRK:  begin op_a = {36'd0, root}; op_b = {16'd0, smoke_work_coeff}; end
      OP_SACC:  begin op_a = {32'd0, accel}; op_b = {16'd0, smoke_accel_coeff}; end
      default:  ;
    endcase
  end

  logic signed [16:0] lim;
  assign lim = 17'sd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      engine_flag <= 1'b0;
      rpm_level <= '0;
      speed_level <= '0;
      prior_speed <= '0;
      smoke_level <= '0;
      op <= OP_SQ;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            if (!action) begin
              if (master_switch) engine_flag <= engine_request;
              state <= ST_OUT;
            end else begin
              t_master <= master_switch;
              t_throttle <= throttle;
              t_brake <= brake;
              t_rev <= (reverser == 2'sb10) ? -2'sd1 : reverser;
              state <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          if (!t_master) engine_flag <= 1'b0;
          if (rpm_calc < 0) rpm_level <= '0;
          else if (rpm_calc > 18'sd25600) rpm_level <= 15'(LEVEL_MAX);
          else rpm_level <= rpm_calc[14:0];
          mag <= speed_level[15] ? 16'(-speed_level) : 16'(speed_level);
          spd <= 17'(speed_level);
          res <= {9'd0, rolling_step};
          smoke <= '0;
          op <= OP_SQ;
          state <= ST_NEXT;
        end
        ST_NEXT: begin
          // Load the unit for the current operation.
          if (op == OP_ROOT) begin
            r_v <= {1'b0, rpm_level, 8'd0};
            r_rem <= '0;
            r_res <= '0;
            r_cnt <= '0;
            state <= ST_SQRT;
          end else begin
            m_a <= op_a;
            m_b <= op_b;
            m_acc <= '0;
            m_cnt <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (m_b[0]) m_acc <= m_acc + m_a;
          m_a <= {m_a[46:0], 1'b0};
          m_b <= {1'b0, m_b[31:1]};
          m_cnt <= m_cnt + 5'd1;
          if (m_cnt == 5'd31) state <= ST_FIN;
        end
        ST_SQRT: begin
          if (!r_trial[25]) begin
            r_rem <= r_trial[23:0];
            r_res <= {r_res[10:0], 1'b1};
          end else begin
            r_rem <= {r_rem[21:0], r_v[23:22]};
            r_res <= {r_res[10:0], 1'b0};
          end
          r_v <= {r_v[21:0], 2'b00};
          r_cnt <= r_cnt + 4'd1;
          if (r_cnt == 4'd11) state <= ST_FIN;
        end
        ST_FIN: begin
          op_t    op_nx;
          state_t st_nx;
          op_nx = op_t'(op + 3'd1);
          st_nx = ST_NEXT;
          unique case (op)
            OP_SQ:    sq <= m_acc[31:0];
            OP_AIR:   res <= res + m_acc[47:24];
            OP_BRAKE: begin
              // Apply drag, never crossing zero.
              logic [23:0] r;
              r = res + 24'(m_acc[47:16]);
              if ({8'd0, mag} > r)
                spd <= speed_level[15] ? spd + 17'(r) : spd - 17'(r);
              else
                spd <= '0;
            end
            OP_ROOT:  root <= r_res;
            OP_DRIVE: begin
              logic signed [21:0] s;
              logic signed [21:0] d;
              d = 22'($signed({1'b0, m_acc[28:8]}));
              s = 22'(spd);
              if (t_master && rpm_level != 0 &&
                  ((t_rev == 2'sd1 && spd > 0) || (t_rev == -2'sd1 && spd < 0) ||
                   (spd < lim && spd > -lim))) begin
                if (t_rev == 2'sd1) s = s + d;
                else if (t_rev == -2'sd1) s = s - d;
              end
              if (s > 22'sd25600) s = 22'sd25600;
              else if (s < -22'sd25600) s = -22'sd25600;
              spd <= s[16:0];
              speed_level <= s[15:0];
              accel <= (s > 22'(prior_speed)) ? 16'(s - 22'(prior_speed)) : 16'd0;
              if (!engine_flag) begin
                smoke_level <= '0;
                prior_speed <= s[15:0];
                st_nx = ST_OUT;
              end else if (t_throttle <= rpm_level) begin
                op_nx = OP_SWRK;
              end
            end
            OP_STHR:  smoke <= smoke + m_acc[32:8];
            OP_SWRK:  smoke <= smoke + m_acc[32:8];
            OP_SACC:  begin
              logic [33:0] t;
              t = {9'd0, smoke} + {1'b0, m_acc[40:8]};
              smoke_level <= (t > 34'd25600) ? 15'(LEVEL_MAX) : t[14:0];
              prior_speed <= speed_level;
              st_nx = ST_OUT;
            end
            default: ;
          endcase
          op <= op_nx;
          state <= st_nx;
        end
        ST_OUT: begin
          out_valid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign speed_out = speed_level;
  assign rpm_out = rpm_level;
  assign smoke_out = smoke_level;
  assign engine_running = engine_flag;

  a_rpm_range: assert property (@(posedge clk) disable iff (rst)
    rpm_level <= 15'(LEVEL_MAX)) else $error("rpm out of range");
  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    speed_level <= 16'sd25600 && speed_level >= -16'sd25600)
    else $error("speed out of range");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(speed_out) && $stable(smoke_out))
    else $error("result changed while stalled");

endmodule
